>>> rtl/kpvb_pkg.sv
// ----------------------------------------------------------------------------
// kpvb_pkg
// Shared types, constants and the filter microcode for the one-axis
// position / velocity / accelerometer-bias Kalman filter.
// ----------------------------------------------------------------------------
package kpvb_pkg;

  localparam int FRAC_BITS_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 48;

  // fixed widths of the ports and of the configuration registers
  localparam int FIELD_W = 48;
  localparam int CFG_W   = 48;
  localparam int CFG_AW  = 3;
  localparam int Q_W     = 47;
  localparam int STEP_W  = 32;

  localparam logic [Q_W-1:0]    Q_POS_RST   = 47'd214748365;
  localparam logic [Q_W-1:0]    Q_VEL_RST   = 47'd214748365;
  localparam logic [Q_W-1:0]    Q_BIAS_RST  = 47'd193273528;
  localparam logic [Q_W-1:0]    R_POS_RST   = 47'd171798692;
  localparam logic [CFG_W-1:0]  MEAS_G_RST  = 48'd4294967296;
  localparam logic [STEP_W-1:0] STEP_T_RST  = 32'd21474836;

  typedef enum logic [CFG_AW-1:0] {
    CFG_POS_NOISE  = 3'd0,
    CFG_VEL_NOISE  = 3'd1,
    CFG_Q_BIAS     = 3'd2,
    CFG_MEAS_NOISE = 3'd3,
    CFG_MEAS_GAIN  = 3'd4,
    CFG_STEP_TIME  = 3'd5
  } cfg_idx_t;

  // operand file: 0..23 stored words, 24..31 live sources
  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = 5;
  typedef logic [RF_AW-1:0] addr_t;

  localparam addr_t A_POS  = 5'd0;
  localparam addr_t A_VEL  = 5'd1;
  localparam addr_t A_BIAS = 5'd2;
  localparam addr_t A_P0   = 5'd3;
  localparam addr_t A_P1   = 5'd4;
  localparam addr_t A_P2   = 5'd5;
  localparam addr_t A_P3   = 5'd6;
  localparam addr_t A_P4   = 5'd7;
  localparam addr_t A_P5   = 5'd8;
  localparam addr_t A_P6   = 5'd9;
  localparam addr_t A_P7   = 5'd10;
  localparam addr_t A_P8   = 5'd11;
  localparam addr_t A_T0   = 5'd12;
  localparam addr_t A_T1   = 5'd13;
  localparam addr_t A_T2   = 5'd14;
  localparam addr_t A_T3   = 5'd15;
  localparam addr_t A_T4   = 5'd16;
  localparam addr_t A_T5   = 5'd17;
  localparam addr_t A_T6   = 5'd18;
  localparam addr_t A_T7   = 5'd19;
  localparam addr_t A_T8   = 5'd20;
  localparam addr_t A_T9   = 5'd21;
  localparam addr_t S_Z    = 5'd24;
  localparam addr_t S_ACC  = 5'd25;
  localparam addr_t S_DT   = 5'd26;
  localparam addr_t S_C    = 5'd27;
  localparam addr_t S_QP   = 5'd28;
  localparam addr_t S_QV   = 5'd29;
  localparam addr_t S_QB   = 5'd30;
  localparam addr_t S_R    = 5'd31;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_NEG  = 3'd2,
    OP_HALF = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_CHK  = 3'd6
  } op_t;

  typedef struct packed {
    op_t   op;
    addr_t dst;
    addr_t a;
    addr_t b;
  } instr_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PC_LAST = 7'd87;

  function automatic instr_t mk(input op_t op, input addr_t d, input addr_t a,
                                input addr_t b);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.a   = a;
    i.b   = b;
    return i;
  endfunction

  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // prediction
      7'd0:  i = mk(OP_SUB,  A_T0,   S_ACC,  A_BIAS);
      7'd1:  i = mk(OP_MUL,  A_T1,   A_T0,   S_DT);
      7'd2:  i = mk(OP_ADD,  A_VEL,  A_VEL,  A_T1);
      7'd3:  i = mk(OP_MUL,  A_T2,   A_T1,   S_DT);
      7'd4:  i = mk(OP_HALF, A_T2,   A_T2,   A_T2);
      7'd5:  i = mk(OP_MUL,  A_T3,   A_VEL,  S_DT);
      7'd6:  i = mk(OP_ADD,  A_T2,   A_T2,   A_T3);
      7'd7:  i = mk(OP_ADD,  A_POS,  A_POS,  A_T2);
      // covariance derivative terms
      7'd8:  i = mk(OP_MUL,  A_T0,   A_P8,   S_DT);
      7'd9:  i = mk(OP_HALF, A_T1,   A_T0,   A_T0);
      7'd10: i = mk(OP_ADD,  A_T2,   S_QP,   A_P1);
      7'd11: i = mk(OP_ADD,  A_T2,   A_T2,   A_P3);
      7'd12: i = mk(OP_HALF, A_T3,   A_P6,   A_P6);
      7'd13: i = mk(OP_SUB,  A_T3,   A_P4,   A_T3);
      7'd14: i = mk(OP_HALF, A_T4,   A_P2,   A_P2);
      7'd15: i = mk(OP_SUB,  A_T3,   A_T3,   A_T4);
      7'd16: i = mk(OP_MUL,  A_T3,   A_T3,   S_DT);
      7'd17: i = mk(OP_ADD,  A_T2,   A_T2,   A_T3);
      7'd18: i = mk(OP_SUB,  A_T3,   A_P4,   A_P2);
      7'd19: i = mk(OP_HALF, A_T4,   A_P7,   A_P7);
      7'd20: i = mk(OP_ADD,  A_T4,   A_T4,   A_P5);
      7'd21: i = mk(OP_MUL,  A_T4,   A_T4,   S_DT);
      7'd22: i = mk(OP_SUB,  A_T3,   A_T3,   A_T4);
      7'd23: i = mk(OP_SUB,  A_T4,   A_P5,   A_T1);
      7'd24: i = mk(OP_SUB,  A_T5,   A_P4,   A_P6);
      7'd25: i = mk(OP_HALF, A_T6,   A_P5,   A_P5);
      7'd26: i = mk(OP_ADD,  A_T6,   A_P7,   A_T6);
      7'd27: i = mk(OP_MUL,  A_T6,   A_T6,   S_DT);
      7'd28: i = mk(OP_SUB,  A_T5,   A_T5,   A_T6);
      7'd29: i = mk(OP_SUB,  A_T6,   S_QV,   A_P7);
      7'd30: i = mk(OP_SUB,  A_T6,   A_T6,   A_P5);
      7'd31: i = mk(OP_ADD,  A_T6,   A_T6,   A_T0);
      7'd32: i = mk(OP_NEG,  A_T7,   A_P8,   A_P8);
      7'd33: i = mk(OP_SUB,  A_T8,   A_P7,   A_T1);
      // Euler step of the covariance
      7'd34: i = mk(OP_MUL,  A_T9,   A_T2,   S_DT);
      7'd35: i = mk(OP_ADD,  A_P0,   A_P0,   A_T9);
      7'd36: i = mk(OP_MUL,  A_T9,   A_T3,   S_DT);
      7'd37: i = mk(OP_ADD,  A_P1,   A_P1,   A_T9);
      7'd38: i = mk(OP_MUL,  A_T9,   A_T4,   S_DT);
      7'd39: i = mk(OP_ADD,  A_P2,   A_P2,   A_T9);
      7'd40: i = mk(OP_MUL,  A_T9,   A_T5,   S_DT);
      7'd41: i = mk(OP_ADD,  A_P3,   A_P3,   A_T9);
      7'd42: i = mk(OP_MUL,  A_T9,   A_T6,   S_DT);
      7'd43: i = mk(OP_ADD,  A_P4,   A_P4,   A_T9);
      7'd44: i = mk(OP_MUL,  A_T9,   A_T7,   S_DT);
      7'd45: i = mk(OP_ADD,  A_P5,   A_P5,   A_T9);
      7'd46: i = mk(OP_MUL,  A_T9,   A_T8,   S_DT);
      7'd47: i = mk(OP_ADD,  A_P6,   A_P6,   A_T9);
      7'd48: i = mk(OP_MUL,  A_T9,   A_T7,   S_DT);
      7'd49: i = mk(OP_ADD,  A_P7,   A_P7,   A_T9);
      7'd50: i = mk(OP_MUL,  A_T9,   S_QB,   S_DT);
      7'd51: i = mk(OP_ADD,  A_P8,   A_P8,   A_T9);
      // innovation variance and gains
      7'd52: i = mk(OP_MUL,  A_T0,   S_C,    A_P0);
      7'd53: i = mk(OP_MUL,  A_T1,   S_C,    A_P3);
      7'd54: i = mk(OP_MUL,  A_T2,   S_C,    A_P6);
      7'd55: i = mk(OP_MUL,  A_T3,   S_C,    A_T0);
      7'd56: i = mk(OP_ADD,  A_T3,   S_R,    A_T3);
      7'd57: i = mk(OP_CHK,  A_T3,   A_T3,   A_T3);
      7'd58: i = mk(OP_DIV,  A_T4,   A_T0,   A_T3);
      7'd59: i = mk(OP_DIV,  A_T5,   A_T1,   A_T3);
      7'd60: i = mk(OP_DIV,  A_T6,   A_T2,   A_T3);
      // state correction
      7'd61: i = mk(OP_SUB,  A_T7,   S_Z,    A_POS);
      7'd62: i = mk(OP_MUL,  A_T8,   A_T4,   A_T7);
      7'd63: i = mk(OP_ADD,  A_POS,  A_POS,  A_T8);
      7'd64: i = mk(OP_MUL,  A_T8,   A_T5,   A_T7);
      7'd65: i = mk(OP_ADD,  A_VEL,  A_VEL,  A_T8);
      7'd66: i = mk(OP_MUL,  A_T8,   A_T6,   A_T7);
      7'd67: i = mk(OP_ADD,  A_BIAS, A_BIAS, A_T8);
      // covariance correction
      7'd68: i = mk(OP_MUL,  A_T7,   S_C,    A_P1);
      7'd69: i = mk(OP_MUL,  A_T8,   S_C,    A_P2);
      7'd70: i = mk(OP_MUL,  A_T9,   A_T4,   A_T0);
      7'd71: i = mk(OP_SUB,  A_P0,   A_P0,   A_T9);
      7'd72: i = mk(OP_MUL,  A_T9,   A_T4,   A_T7);
      7'd73: i = mk(OP_SUB,  A_P1,   A_P1,   A_T9);
      7'd74: i = mk(OP_MUL,  A_T9,   A_T4,   A_T8);
      7'd75: i = mk(OP_SUB,  A_P2,   A_P2,   A_T9);
      7'd76: i = mk(OP_MUL,  A_T9,   A_T5,   A_T0);
      7'd77: i = mk(OP_SUB,  A_P3,   A_P3,   A_T9);
      7'd78: i = mk(OP_MUL,  A_T9,   A_T5,   A_T7);
      7'd79: i = mk(OP_SUB,  A_P4,   A_P4,   A_T9);
      7'd80: i = mk(OP_MUL,  A_T9,   A_T5,   A_T8);
      7'd81: i = mk(OP_SUB,  A_P5,   A_P5,   A_T9);
      7'd82: i = mk(OP_MUL,  A_T9,   A_T6,   A_T0);
      7'd83: i = mk(OP_SUB,  A_P6,   A_P6,   A_T9);
      7'd84: i = mk(OP_MUL,  A_T9,   A_T6,   A_T7);
      7'd85: i = mk(OP_SUB,  A_P7,   A_P7,   A_T9);
      7'd86: i = mk(OP_MUL,  A_T9,   A_T6,   A_T8);
      7'd87: i = mk(OP_SUB,  A_P8,   A_P8,   A_T9);
      default: i = mk(OP_ADD, A_T9, A_T9, A_T9);
    endcase
    return i;
  endfunction

endpackage

>>> rtl/kpvb_serial.sv
// ----------------------------------------------------------------------------
// kpvb_serial
// Bit-serial saturating fixed-point multiplier and restoring divider.
// One product or quotient bit per cycle, then round products and clamp.
// ----------------------------------------------------------------------------
module kpvb_serial #(
  parameter int DW = kpvb_pkg::DATA_WIDTH_DEF,
  parameter int FW = kpvb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kpvb_pkg::md_ctrl_t   ctrl,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output kpvb_pkg::md_stat_t   stat,
  output logic signed [DW-1:0] result
);

  localparam int NW = DW + FW;
  localparam int CW = $clog2(NW + 1);
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [2*DW:0] RND  = (2*DW+1)'(1) << (FW - 1);

  logic          busy;
  logic          done;
  logic          is_div;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW-1:0] x;
  logic [2*DW:0] prod;
  logic [DW:0]   rem;
  logic [NW-1:0] num;
  logic [NW-1:0] quot;

  logic [DW:0]   hi_sum;
  logic [DW:0]   r2;
  logic          qbit;
  logic [2*DW:0] rsum;
  logic          big;
  logic [DW-1:0] m;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    hi_sum = prod[0] ? (prod[2*DW:DW] + {1'b0, x}) : prod[2*DW:DW];
    r2     = {rem[DW-1:0], num[NW-1]};
    qbit   = (r2 >= {1'b0, x});
    rsum   = {1'b0, prod[2*DW-1:0]} + RND;
    if (is_div) begin
      big = |quot[NW-1:DW-1];
      m   = quot[DW-1:0];
    end else begin
      big = |rsum[2*DW:FW+DW-1];
      m   = rsum[FW+DW-1:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        is_div <= ctrl.is_div;
        neg    <= a[DW-1] ^ b[DW-1];
        x      <= ctrl.is_div ? mag(b) : mag(a);
        prod   <= {{(DW+1){1'b0}}, mag(b)};
        num    <= {mag(a), {FW{1'b0}}};
        rem    <= '0;
        quot   <= '0;
        cnt    <= ctrl.is_div ? CW'(NW) : CW'(DW);
      end else if (busy && cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (is_div) begin
          rem  <= qbit ? (r2 - {1'b0, x}) : r2;
          num  <= {num[NW-2:0], 1'b0};
          quot <= {quot[NW-2:0], qbit};
        end else begin
          prod <= {1'b0, hi_sum, prod[DW-1:1]};
        end
      end else if (busy) begin
        // round products, clamp, apply sign
        busy <= 1'b0;
        done <= 1'b1;
        if (big) result <= neg ? VMIN : VMAX;
        else     result <= neg ? DW'(-m) : m;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/kpvb_regfile.sv
// ----------------------------------------------------------------------------
// kpvb_regfile
// Filter state and scratch words: one write port, two registered read ports.
// Words never written read as their reset value (identity covariance).
// ----------------------------------------------------------------------------
module kpvb_regfile #(
  parameter int DW = kpvb_pkg::DATA_WIDTH_DEF,
  parameter int FW = kpvb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  kpvb_pkg::addr_t       waddr,
  input  logic [DW-1:0]         wdata,
  input  kpvb_pkg::addr_t       raddr_a,
  input  kpvb_pkg::addr_t       raddr_b,
  output logic [DW-1:0]         rdata_a,
  output logic [DW-1:0]         rdata_b
);

  localparam logic [DW-1:0] ONE = (FW < DW - 1) ? (DW'(1) << FW)
                                                : {1'b0, {(DW-1){1'b1}}};

  logic [DW-1:0]                  mem [kpvb_pkg::RF_DEPTH];
  logic [kpvb_pkg::RF_DEPTH-1:0]  vld;
  logic [DW-1:0]                  mem_a;
  logic [DW-1:0]                  mem_b;
  logic                           vld_a;
  logic                           vld_b;
  kpvb_pkg::addr_t                addr_a;
  kpvb_pkg::addr_t                addr_b;

  function automatic logic [DW-1:0] init_val(input kpvb_pkg::addr_t ad);
    return (ad == kpvb_pkg::A_P0 || ad == kpvb_pkg::A_P4 || ad == kpvb_pkg::A_P8)
           ? ONE : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_a  <= mem[raddr_a];
    mem_b  <= mem[raddr_b];
    addr_a <= raddr_a;
    addr_b <= raddr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      vld_a <= vld[raddr_a];
      vld_b <= vld[raddr_b];
    end
  end

  assign rdata_a = vld_a ? mem_a : init_val(addr_a);
  assign rdata_b = vld_b ? mem_b : init_val(addr_b);

endmodule

>>> rtl/kalman_pos_vel_bias_fusion.sv
// ----------------------------------------------------------------------------
// kalman_pos_vel_bias_fusion
// One-axis Kalman filter: position, velocity and accelerometer bias with a
// 3x3 covariance, saturating signed fixed point, microcoded over one
// bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------
//  input    | in_valid / in_stall           | pos_meas, accel
//  output   | out_valid / out_stall         | pos_est, vel_est, bias_est,
//           |                               | div_fault
//  config   | cfg_wr                        | cfg_idx, cfg_data
//
//  An item runs 88 microcode steps: 34 multiplies, 3 divides, one zero
//  check and 50 other steps, plus taking the input and loading the output;
//  the serial multiply/divide unit sets the run time. A zero innovation
//  variance ends the item after 58 steps. Reset clears state to zero,
//  covariance to identity and the registers to their defaults; no clearing
//  pass. A new item is taken once the previous result sits in the output
//  register, which holds until out_stall drops.
// ----------------------------------------------------------------------------
module kalman_pos_vel_bias_fusion #(
  parameter int DATA_WIDTH = kpvb_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kpvb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [kpvb_pkg::FIELD_W-1:0] pos_meas,
  input  logic signed [kpvb_pkg::FIELD_W-1:0] accel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [kpvb_pkg::FIELD_W-1:0] pos_est,
  output logic signed [kpvb_pkg::FIELD_W-1:0] vel_est,
  output logic signed [kpvb_pkg::FIELD_W-1:0] bias_est,
  output logic                               div_fault,
  input  logic                               cfg_wr,
  input  logic [kpvb_pkg::CFG_AW-1:0]        cfg_idx,
  input  logic [kpvb_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [64:0] VMAX_W = (65'sd1 <<< (DW - 1)) - 65'sd1;
  localparam logic signed [64:0] VMIN_W = -VMAX_W - 65'sd1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_WAIT = 6'b001000,
    S_WB   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                   state;
  logic [kpvb_pkg::PC_W-1:0] pc;
  kpvb_pkg::instr_t         ins;
  logic                     fault;
  logic [DW-1:0]            res;
  logic [DW-1:0]            alu;
  logic [DW-1:0]            z;
  logic [DW-1:0]            acc;
  logic [DW-1:0]            pos_sh;
  logic [DW-1:0]            vel_sh;
  logic [DW-1:0]            bias_sh;

  logic [kpvb_pkg::Q_W-1:0]    pos_noise;
  logic [kpvb_pkg::Q_W-1:0]    vel_noise;
  logic [kpvb_pkg::Q_W-1:0]    q_bias;
  logic [kpvb_pkg::Q_W-1:0]    meas_noise;
  logic signed [kpvb_pkg::CFG_W-1:0] meas_gain;
  logic [kpvb_pkg::STEP_W-1:0] step_time;

  logic [DW-1:0]      rf_a;
  logic [DW-1:0]      rf_b;
  logic [DW-1:0]      opa;
  logic [DW-1:0]      opb;
  logic               rf_we;
  kpvb_pkg::md_ctrl_t md_ctrl;
  kpvb_pkg::md_stat_t md_stat;
  logic [DW-1:0]      md_res;

  function automatic logic [DW-1:0] sat_w(input logic signed [64:0] w);
    if (w > VMAX_W) return VMAX;
    if (w < VMIN_W) return VMIN;
    return w[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sadd(input logic [DW-1:0] x,
                                         input logic [DW-1:0] y);
    logic [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sneg(input logic [DW-1:0] x);
    return (x == VMIN) ? VMAX : DW'(-x);
  endfunction

  // divide by two, truncating toward zero
  function automatic logic [DW-1:0] shalf(input logic [DW-1:0] x);
    logic [DW:0] s;
    s = {x[DW-1], x} + (DW+1)'(x[DW-1]);
    return s[DW:1];
  endfunction

  function automatic logic [kpvb_pkg::FIELD_W-1:0] to_field(input logic [DW-1:0] x);
    logic signed [64:0] w;
    w = 65'($signed(x));
    return w[kpvb_pkg::FIELD_W-1:0];
  endfunction

  function automatic logic [DW-1:0] operand(input kpvb_pkg::addr_t ad,
                                            input logic [DW-1:0] rf);
    logic [DW-1:0] v;
    case (ad)
      kpvb_pkg::S_Z:   v = z;
      kpvb_pkg::S_ACC: v = acc;
      kpvb_pkg::S_DT:  v = sat_w($signed(65'(step_time)));
      kpvb_pkg::S_C:   v = sat_w(65'(meas_gain));
      kpvb_pkg::S_QP:  v = sat_w($signed(65'(pos_noise)));
      kpvb_pkg::S_QV:  v = sat_w($signed(65'(vel_noise)));
      kpvb_pkg::S_QB:  v = sat_w($signed(65'(q_bias)));
      kpvb_pkg::S_R:   v = sat_w($signed(65'(meas_noise)));
      default:         v = rf;
    endcase
    return v;
  endfunction

  assign ins = kpvb_pkg::prog(pc);
  assign opa = operand(ins.a, rf_a);
  assign opb = operand(ins.b, rf_b);

  always_comb begin
    case (ins.op)
      kpvb_pkg::OP_ADD:  alu = sadd(opa, opb);
      kpvb_pkg::OP_SUB:  alu = sadd(opa, sneg(opb));
      kpvb_pkg::OP_NEG:  alu = sneg(opa);
      kpvb_pkg::OP_HALF: alu = shalf(opa);
      default:           alu = opa;
    endcase
  end

  assign md_ctrl.start  = (state == S_EXEC) &&
                          (ins.op == kpvb_pkg::OP_MUL || ins.op == kpvb_pkg::OP_DIV);
  assign md_ctrl.is_div = (ins.op == kpvb_pkg::OP_DIV);
  assign rf_we          = (state == S_WB);
  assign in_stall       = (state != S_IDLE);

  kpvb_regfile #(.DW(DW), .FW(FRAC_BITS)) u_rf (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (ins.dst),
    .wdata   (res),
    .raddr_a (ins.a),
    .raddr_b (ins.b),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  kpvb_serial #(.DW(DW), .FW(FRAC_BITS)) u_md (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (md_ctrl),
    .a      (opa),
    .b      (opb),
    .stat   (md_stat),
    .result (md_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_noise  <= kpvb_pkg::Q_POS_RST;
      vel_noise  <= kpvb_pkg::Q_VEL_RST;
      q_bias     <= kpvb_pkg::Q_BIAS_RST;
      meas_noise <= kpvb_pkg::R_POS_RST;
      meas_gain  <= kpvb_pkg::MEAS_G_RST;
      step_time  <= kpvb_pkg::STEP_T_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        kpvb_pkg::CFG_POS_NOISE:  pos_noise  <= cfg_data[kpvb_pkg::Q_W-1:0];
        kpvb_pkg::CFG_VEL_NOISE:  vel_noise  <= cfg_data[kpvb_pkg::Q_W-1:0];
        kpvb_pkg::CFG_Q_BIAS:     q_bias     <= cfg_data[kpvb_pkg::Q_W-1:0];
        kpvb_pkg::CFG_MEAS_NOISE: meas_noise <= cfg_data[kpvb_pkg::Q_W-1:0];
        kpvb_pkg::CFG_MEAS_GAIN:  meas_gain  <= cfg_data;
        kpvb_pkg::CFG_STEP_TIME:  step_time  <= cfg_data[kpvb_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
      pos_sh    <= '0;
      vel_sh    <= '0;
      bias_sh   <= '0;
    end else begin
      // in S_DONE the output register is handled below
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            z     <= sat_w(65'(pos_meas));
            acc   <= sat_w(65'(accel));
            pc    <= '0;
            fault <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (md_ctrl.start) begin
            state <= S_WAIT;
          end else if (ins.op == kpvb_pkg::OP_CHK) begin
            if (opa == '0) begin
              fault <= 1'b1;
              state <= S_DONE;
            end else begin
              pc    <= pc + kpvb_pkg::PC_W'(1);
              state <= S_READ;
            end
          end else begin
            res   <= alu;
            state <= S_WB;
          end
        end
        S_WAIT: begin
          if (md_stat.done) begin
            res   <= md_res;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (ins.dst == kpvb_pkg::A_POS)  pos_sh  <= res;
          if (ins.dst == kpvb_pkg::A_VEL)  vel_sh  <= res;
          if (ins.dst == kpvb_pkg::A_BIAS) bias_sh <= res;
          if (pc == kpvb_pkg::PC_LAST) begin
            state <= S_DONE;
          end else begin
            pc    <= pc + kpvb_pkg::PC_W'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            pos_est   <= to_field(pos_sh);
            vel_est   <= to_field(vel_sh);
            bias_est  <= to_field(bias_sh);
            div_fault <= fault;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_READ && pc == '0))
    else $error("accepted transaction did not start the program");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> (state == S_WAIT))
    else $error("multiply/divide finished outside wait");

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (md_stat.busy || md_stat.done))
    else $error("waiting on idle multiply/divide unit");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= kpvb_pkg::PC_LAST)
    else $error("program counter past last step");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives position / acceleration samples into the one-axis Kalman filter
// under several noise, gain and step settings. A saturating fixed-point
// predictor in the scoreboard computes each expected estimate, and every
// output transaction is compared field by field. The input idles and the
// output stalls at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FIELD_W = kpvb_pkg::FIELD_W;
  localparam int CFG_W   = kpvb_pkg::CFG_W;
  localparam int CFG_AW  = kpvb_pkg::CFG_AW;
  localparam int Q_W     = kpvb_pkg::Q_W;
  localparam int STEP_W  = kpvb_pkg::STEP_W;

  localparam longint VMAX = 64'sd140737488355327;
  localparam longint VMIN = -VMAX - 1;
  localparam logic [CFG_AW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    longint pos;
    longint vel;
    longint bias;
    bit     fault;
  } estimate_t;

  class fusion_scoreboard;
    longint q_pos, q_vel, q_bias, r_pos, gain, dt;
    longint pos, vel, bias;
    longint cov[9];
    estimate_t expected_est[$];
    int errors;

    function new();
      q_pos = kpvb_pkg::Q_POS_RST;
      q_vel = kpvb_pkg::Q_VEL_RST;
      q_bias = kpvb_pkg::Q_BIAS_RST;
      r_pos = kpvb_pkg::R_POS_RST;
      gain = $signed(kpvb_pkg::MEAS_G_RST);
      dt = kpvb_pkg::STEP_T_RST;
      pos = 0;
      vel = 0;
      bias = 0;
      foreach (cov[i]) cov[i] = 0;
      cov[0] = 64'sd1 << 32;
      cov[4] = cov[0];
      cov[8] = cov[0];
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        kpvb_pkg::CFG_POS_NOISE:  q_pos = {17'd0, data[Q_W-1:0]};
        kpvb_pkg::CFG_VEL_NOISE:  q_vel = {17'd0, data[Q_W-1:0]};
        kpvb_pkg::CFG_Q_BIAS:     q_bias = {17'd0, data[Q_W-1:0]};
        kpvb_pkg::CFG_MEAS_NOISE: r_pos = {17'd0, data[Q_W-1:0]};
        kpvb_pkg::CFG_MEAS_GAIN:  gain = longint'($signed(data));
        kpvb_pkg::CFG_STEP_TIME:  dt = {32'd0, data[STEP_W-1:0]};
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
    endfunction

    function longint add(longint a, longint b);
      return sat(a + b);
    endfunction

    function longint neg(longint a);
      return sat(-a);
    endfunction

    function longint sub(longint a, longint b);
      return add(a, neg(b));
    endfunction

    function longint half(longint a);
      return a / 2;
    endfunction

    function longint signed_mag(bit negative, logic [127:0] m);
      if (m > 128'(VMAX)) return negative ? VMIN : VMAX;
      return negative ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // rounded to nearest, ties away from zero
    function longint mul(longint a, longint b);
      logic [127:0] x, y, p;
      x = (a < 0) ? 128'(-a) : 128'(a);
      y = (b < 0) ? 128'(-b) : 128'(b);
      p = (x * y + (128'd1 << 31)) >> 32;
      return signed_mag((a < 0) != (b < 0), p);
    endfunction

    // truncates toward zero
    function longint quo(longint n, longint d);
      logic [127:0] x, y;
      x = (n < 0) ? 128'(-n) : 128'(n);
      y = (d < 0) ? 128'(-d) : 128'(d);
      return signed_mag((n < 0) != (d < 0), (x << 32) / y);
    endfunction

    function void note_sample(logic signed [FIELD_W-1:0] meas,
                              logic signed [FIELD_W-1:0] acc_in);
      longint pd[9];
      longint ab, e, k0, k1, k2, pc0, pc1, pc2, t1, t2, innov, p22;
      estimate_t est;
      ab = sub(longint'(acc_in), bias);
      vel = add(vel, mul(ab, dt));
      pos = add(pos, add(half(mul(mul(ab, dt), dt)), mul(vel, dt)));

      p22 = mul(cov[8], dt);
      pd[0] = add(add(add(q_pos, cov[1]), cov[3]),
                  mul(sub(sub(cov[4], half(cov[6])), half(cov[2])), dt));
      pd[1] = sub(sub(cov[4], cov[2]), mul(add(half(cov[7]), cov[5]), dt));
      pd[2] = sub(cov[5], half(p22));
      pd[3] = sub(sub(cov[4], cov[6]), mul(add(cov[7], half(cov[5])), dt));
      pd[4] = add(sub(sub(q_vel, cov[7]), cov[5]), p22);
      pd[5] = neg(cov[8]);
      pd[6] = sub(cov[7], half(p22));
      pd[7] = neg(cov[8]);
      pd[8] = q_bias;
      foreach (cov[i]) cov[i] = add(cov[i], mul(pd[i], dt));

      pc0 = mul(gain, cov[0]);
      pc1 = mul(gain, cov[3]);
      pc2 = mul(gain, cov[6]);
      e = add(r_pos, mul(gain, pc0));
      est.fault = (e == 0);
      if (!est.fault) begin
        k0 = quo(pc0, e);
        k1 = quo(pc1, e);
        k2 = quo(pc2, e);
        innov = sub(longint'(meas), pos);
        pos = add(pos, mul(k0, innov));
        vel = add(vel, mul(k1, innov));
        bias = add(bias, mul(k2, innov));
        t1 = mul(gain, cov[1]);
        t2 = mul(gain, cov[2]);
        cov[0] = sub(cov[0], mul(k0, pc0));
        cov[1] = sub(cov[1], mul(k0, t1));
        cov[2] = sub(cov[2], mul(k0, t2));
        cov[3] = sub(cov[3], mul(k1, pc0));
        cov[4] = sub(cov[4], mul(k1, t1));
        cov[5] = sub(cov[5], mul(k1, t2));
        cov[6] = sub(cov[6], mul(k2, pc0));
        cov[7] = sub(cov[7], mul(k2, t1));
        cov[8] = sub(cov[8], mul(k2, t2));
      end
      est.pos = pos;
      est.vel = vel;
      est.bias = bias;
      expected_est.push_back(est);
    endfunction

    function void check_estimate(longint p, longint v, longint b, bit f);
      estimate_t ex;
      if (expected_est.size() == 0) begin
        $display("%0t: unexpected output transaction pos=%0d", $time, p);
        errors++;
        return;
      end
      ex = expected_est.pop_front();
      if (p != ex.pos) begin
        $display("%0t: pos_est expected %0d actual %0d", $time, ex.pos, p);
        errors++;
      end
      if (v != ex.vel) begin
        $display("%0t: vel_est expected %0d actual %0d", $time, ex.vel, v);
        errors++;
      end
      if (b != ex.bias) begin
        $display("%0t: bias_est expected %0d actual %0d", $time, ex.bias, b);
        errors++;
      end
      if (f != ex.fault) begin
        $display("%0t: div_fault expected %0d actual %0d", $time, ex.fault, f);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall;
  logic signed [FIELD_W-1:0] pos_meas, accel;
  logic out_valid, out_stall;
  logic signed [FIELD_W-1:0] pos_est, vel_est, bias_est;
  logic div_fault;
  logic cfg_wr;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  fusion_scoreboard sb = new();
  bit quiet;

  kalman_pos_vel_bias_fusion i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_meas(pos_meas), .accel(accel),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_est(pos_est), .vel_est(vel_est), .bias_est(bias_est),
    .div_fault(div_fault),
    .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FIELD_W'($signed($urandom_range(0, 32'hFFFF_FFFF)) <<< 4);
    if (r < 85) return FIELD_W'({$urandom, $urandom});
    if (r < 90) return {1'b0, {(FIELD_W-1){1'b1}}};
    if (r < 95) return {1'b1, {(FIELD_W-1){1'b0}}};
    return '0;
  endfunction

  // output stall: runs of random length, sometimes long
  always @(posedge clk) begin
    if (!rst && !out_stall && $urandom_range(0, 3) == 0 && !quiet)
      out_stall <= (idle_len() != 0);
    else if (out_stall && $urandom_range(0, 7) == 0)
      out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_estimate(longint'(pos_est), longint'(vel_est), longint'(bias_est),
                        div_fault);
  end

  task automatic send_sample(logic [FIELD_W-1:0] meas, logic [FIELD_W-1:0] acc_in);
    int gap;
    in_valid <= 1'b1;
    pos_meas <= meas;
    accel <= acc_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(meas, acc_in);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_est.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_W-1:0] vals[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_wr <= 1'b1;
      cfg_idx <= CFG_AW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_AW'(i), vals[i]);
    end
    // spare indexes must not disturb anything
    cfg_idx <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_data <= CFG_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_setting(int idx);
    int r;
    r = $urandom_range(0, 9);
    if (idx == kpvb_pkg::CFG_STEP_TIME) begin
      if (r < 6) return CFG_W'($urandom_range(1000, 100_000_000));
      if (r < 8) return CFG_W'($urandom);
      return (r == 8) ? '0 : 48'hFFFF_FFFF;
    end
    if (r < 5) return CFG_W'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 8));
    if (r < 7)
      return (idx == kpvb_pkg::CFG_MEAS_GAIN) ? 48'($signed($urandom)) <<< 4
                                              : 48'($urandom);
    if (r < 9) return CFG_W'({$urandom, $urandom});
    return '0;
  endfunction

  initial begin
    logic [CFG_W-1:0] vals[6];
    int count;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pos_meas <= '0;
    accel <= '0;
    out_stall <= 1'b0;
    cfg_wr <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes
    send_sample('0, '0);
    send_sample(48'sh7FFF_FFFF_FFFF, '0);
    send_sample(48'sh8000_0000_0000, '0);
    send_sample('0, 48'sh7FFF_FFFF_FFFF);
    send_sample('0, 48'sh8000_0000_0000);
    send_sample(48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
    send_sample(48'sh8000_0000_0000, 48'sh8000_0000_0000);
    send_sample(48'h1_0000_0000, 48'h0_8000_0000);
    drain();

    // zero innovation variance: correction skipped
    vals = '{48'd5, 48'd7, 48'd3, 48'd0, 48'd0, 48'd21474836};
    load_settings(vals);
    for (int i = 0; i < 5; i++) send_sample(rand_field(), rand_field());
    drain();

    // every register at its maximum
    vals = '{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
             48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF};
    load_settings(vals);
    for (int i = 0; i < 4; i++) send_sample(rand_field(), rand_field());
    drain();

    // most negative gain, zero step and process noise, maximum measurement noise
    vals = '{48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd0};
    load_settings(vals);
    for (int i = 0; i < 4; i++) send_sample(rand_field(), rand_field());
    drain();

    count = 0;
    for (int ph = 0; count < 1850; ph++) begin
      quiet = (ph % 4 == 3);
      if (ph > 0) begin
        foreach (vals[i]) vals[i] = rand_setting(i);
        load_settings(vals);
      end
      for (int i = 0; i < 200 && count < 1850; i++) begin
        send_sample(rand_field(), rand_field());
        count++;
      end
      drain();
    end

    quiet = 1'b1;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_est.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
